// ===== design/cpu_bus_address_decoder_core_assert.svh =====
// Assertion macros for the bus address decoder.
`ifndef CPU_BUS_ADDRESS_DECODER_CORE_ASSERT_SVH
`define CPU_BUS_ADDRESS_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CBAD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("decoder assertion failed");
`define CBAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("decoder assertion failed");
`else
`define CBAD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CBAD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/cbad_pkg.sv =====
// Types, codes and constants shared by the bus address decoder.
package cbad_pkg;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_DEBUG = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		TGT_NONE     = 4'd0,
		TGT_MEMORY   = 4'd1,
		TGT_MMU      = 4'd2,
		TGT_SERIAL_A = 4'd3,
		TGT_DISK     = 4'd4,
		TGT_NET      = 4'd5,
		TGT_PARALLEL = 4'd6,
		TGT_CLOCK    = 4'd7,
		TGT_SERIAL_B = 4'd8,
		TGT_MMU_LATCH = 4'd9,
		TGT_DEBUG    = 4'd10,
		TGT_LATCH    = 4'd11
	} target_t;

	localparam int unsigned CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] CFG_SERIAL_A_PRESENT = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_SERIAL_A_NARROW  = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_DISK_PRESENT     = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_NET_PRESENT      = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_CLOCK_PRESENT    = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_SERIAL_B_PRESENT = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_MMU_PRESENT      = 3'd6;

	localparam logic [1:0] QUAD_MEMORY = 2'd0;
	localparam logic [1:0] QUAD_LATCH  = 2'd2;
	localparam logic [1:0] QUAD_IO     = 2'd3;

	localparam logic [7:0] PORT_MMU_LATCH = 8'h38;
	localparam logic [7:0] PORT_DEBUG     = 8'h00;
	localparam logic [7:0] PORT_CLOCK     = 8'h0C;
	localparam logic [7:0] PORT_NET_LO    = 8'h28;
	localparam logic [7:0] PORT_NET_HI    = 8'h2C;

	typedef struct packed {
		logic serial_a_present;
		logic serial_a_narrow;
		logic disk_present;
		logic net_present;
		logic clock_present;
		logic serial_b_present;
		logic mmu_present;
	} cfg_t;

	localparam cfg_t FITTED_AT_RESET = '{serial_b_present: 1'b1, default: 1'b0};

	typedef struct packed {
		target_t     target;
		logic [19:0] target_address;
		logic [7:0]  data_out;
		logic        is_write;
		logic        supervisor;
	} res_t;

endpackage

// ===== design/cbad_cfg.sv =====
// Configuration register file of the bus address decoder.
module cbad_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [cbad_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic                          cfg_data,
	output cbad_pkg::cfg_t                cfg
);

	cbad_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= cbad_pkg::FITTED_AT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cbad_pkg::CFG_SERIAL_A_PRESENT: cfg_q.serial_a_present <= cfg_data;
				cbad_pkg::CFG_SERIAL_A_NARROW:  cfg_q.serial_a_narrow  <= cfg_data;
				cbad_pkg::CFG_DISK_PRESENT:     cfg_q.disk_present     <= cfg_data;
				cbad_pkg::CFG_NET_PRESENT:      cfg_q.net_present      <= cfg_data;
				cbad_pkg::CFG_CLOCK_PRESENT:    cfg_q.clock_present    <= cfg_data;
				cbad_pkg::CFG_SERIAL_B_PRESENT: cfg_q.serial_b_present <= cfg_data;
				cbad_pkg::CFG_MMU_PRESENT:      cfg_q.mmu_present      <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/cbad_decode.sv =====
// Combinational decode of one bus access into a target and address.
module cbad_decode (
	input  cbad_pkg::op_t   op,
	input  logic [23:0]     bus_address,
	input  logic [7:0]      write_data,
	input  cbad_pkg::cfg_t  cfg,
	input  logic [7:0]      latch,
	output cbad_pkg::res_t  res,
	output logic            latch_we
);

	logic        wr;
	logic        locked;
	logic [1:0]  quad;
	logic [7:0]  port;
	logic [19:0] mem_addr;
	logic [19:0] xlate_addr;
	cbad_pkg::target_t io_tgt;
	logic [3:0]  io_off;

	assign wr         = (op == cbad_pkg::OP_WRITE);
	assign locked     = latch[0];
	assign quad       = bus_address[23:22];
	assign port       = bus_address[15:8];
	assign mem_addr   = {bus_address[19] | latch[2], bus_address[18:16],
		bus_address[7:0], bus_address[15:8]};
	assign xlate_addr = {2'b00, bus_address[17:16], bus_address[15:0]};

	always_comb begin
		io_tgt = cbad_pkg::TGT_NONE;
		io_off = '0;
		priority if (cfg.serial_a_present && cfg.serial_a_narrow
				&& port[7:3] == 5'b10000) begin
			io_tgt = cbad_pkg::TGT_SERIAL_A;
			io_off = {3'b000, port[0]};
		end else if (cfg.serial_a_present && !cfg.serial_a_narrow
				&& port[7:6] == 2'b10) begin
			io_tgt = cbad_pkg::TGT_SERIAL_A;
			io_off = {3'b000, port[0]};
		end else if (cfg.disk_present && port[7:3] == 5'b00010) begin
			io_tgt = cbad_pkg::TGT_DISK;
			io_off = {1'b0, port[2:0]};
		end else if (cfg.net_present && port >= cbad_pkg::PORT_NET_LO
				&& port <= cbad_pkg::PORT_NET_HI) begin
			io_tgt = cbad_pkg::TGT_NET;
			io_off = {2'b00, port[1:0]};
		end else if (wr && cfg.mmu_present && port == cbad_pkg::PORT_MMU_LATCH) begin
			io_tgt = cbad_pkg::TGT_MMU_LATCH;
		end else if (port[7:4] == 4'h6) begin
			io_tgt = cbad_pkg::TGT_PARALLEL;
			io_off = port[3:0];
		end else if (cfg.clock_present && port == cbad_pkg::PORT_CLOCK) begin
			io_tgt = cbad_pkg::TGT_CLOCK;
		end else if (cfg.serial_b_present && port[7:4] == 4'hC) begin
			io_tgt = cbad_pkg::TGT_SERIAL_B;
			io_off = port[3:0];
		end else if (wr && port == cbad_pkg::PORT_DEBUG) begin
			io_tgt = cbad_pkg::TGT_DEBUG;
		end else begin
			io_tgt = cbad_pkg::TGT_NONE;
		end
	end

	always_comb begin
		res            = '0;
		res.target     = cbad_pkg::TGT_NONE;
		res.supervisor = ~locked;
		latch_we       = 1'b0;
		priority if (op == cbad_pkg::OP_NONE) begin
			res.target = cbad_pkg::TGT_NONE;
		end else if (quad == cbad_pkg::QUAD_MEMORY) begin
			if (!(wr && !mem_addr[19])) begin
				res.is_write = wr;
				res.data_out = wr ? write_data : 8'h00;
				if (cfg.mmu_present && mem_addr[19]) begin
					res.target         = cbad_pkg::TGT_MMU;
					res.target_address = xlate_addr;
				end else begin
					res.target         = cbad_pkg::TGT_MEMORY;
					res.target_address = mem_addr;
				end
			end
		end else if (quad == cbad_pkg::QUAD_LATCH) begin
			if (wr && !locked) begin
				latch_we     = 1'b1;
				res.target   = cbad_pkg::TGT_LATCH;
				res.data_out = write_data;
				res.is_write = 1'b1;
			end
		end else if (quad == cbad_pkg::QUAD_IO) begin
			if (op != cbad_pkg::OP_DEBUG && !locked
					&& io_tgt != cbad_pkg::TGT_NONE) begin
				res.target         = io_tgt;
				res.target_address = {16'h0000, io_off};
				res.data_out       = wr ? write_data : 8'h00;
				res.is_write       = wr;
			end
		end else begin
			res.target = cbad_pkg::TGT_NONE;
		end
	end

endmodule

// ===== design/cpu_bus_address_decoder_core.sv =====
// Top level of the bus address decoder: input stage, decode, result stage.
//
// One bus access enters per s_tvalid/s_tready word: tuser carries the op
// code, tdata the 24-bit bus address and the write byte. Each access gives
// exactly one result word on the m_ group: tuser is the target code, tdata
// the target address or register offset, the write byte, the write flag
// and the supervisor flag.
// Device presence bits are written through cfg_valid/cfg_index/cfg_data,
// always ready; write them only while no access is in flight.
// An accepted access is held in the input register, decoded, and loaded
// into the result register, which drives m_tvalid. One access is taken
// every cycle unless m_tready stalls, set by the single decode stage
// between the input and result registers. The control latch is written in
// the same edge that loads the result, so the next access already sees it.
// When the receiver holds m_tready low, the result register holds, the
// input register fills, and s_tready then drops until the result moves.
// Reset clears both stages, the control latch and the presence bits
// (second serial controller marked fitted).
`include "cpu_bus_address_decoder_core_assert.svh"

module cpu_bus_address_decoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,   // bus_address[23:0], write_data[31:24]
	input  logic [1:0]                    s_tuser,   // op[1:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,   // target_address[19:0], data_out[27:20],
	                                                 // is_write[28], supervisor[29], zero[31:30]
	output logic [3:0]                    m_tuser,   // target[3:0]
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cbad_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic                          cfg_data
);

	cbad_pkg::cfg_t   cfg;
	cbad_pkg::res_t   dec_res;
	logic             dec_latch_we;

	logic             valid_s1;
	cbad_pkg::op_t    op_s1;
	logic [23:0]      addr_s1;
	logic [7:0]       wdata_s1;
	logic             valid_s2;
	cbad_pkg::res_t   res_s2;
	logic [7:0]       latch_q;
	logic             load_s2;
	logic             take_s1;

	assign cfg_ready = 1'b1;

	cbad_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign load_s2  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || load_s2;
	assign take_s1  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			latch_q  <= '0;
		end else begin
			if (take_s1) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
			if (load_s2 && dec_latch_we) begin
				latch_q <= wdata_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			op_s1    <= cbad_pkg::op_t'(s_tuser);
			addr_s1  <= s_tdata[23:0];
			wdata_s1 <= s_tdata[31:24];
		end
		if (load_s2) begin
			res_s2 <= dec_res;
		end
	end

	cbad_decode u_decode (
		.op          (op_s1),
		.bus_address (addr_s1),
		.write_data  (wdata_s1),
		.cfg         (cfg),
		.latch       (latch_q),
		.res         (dec_res),
		.latch_we    (dec_latch_we)
	);

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.target;
	assign m_tdata  = {2'b00, res_s2.supervisor, res_s2.is_write, res_s2.data_out,
		res_s2.target_address};

	`CBAD_ASSERT_IMP(a_none_clean, clk, arst_n,
		valid_s2 && res_s2.target == cbad_pkg::TGT_NONE,
		res_s2.target_address == 20'h0 && res_s2.data_out == 8'h00 && !res_s2.is_write)
	`CBAD_ASSERT_IMP(a_latch_is_write, clk, arst_n,
		valid_s2 && res_s2.target == cbad_pkg::TGT_LATCH,
		res_s2.is_write && res_s2.target_address == 20'h0)
	`CBAD_ASSERT_IMP(a_locked_no_io, clk, arst_n,
		valid_s2 && !res_s2.supervisor,
		res_s2.target == cbad_pkg::TGT_NONE || res_s2.target == cbad_pkg::TGT_MEMORY
		|| res_s2.target == cbad_pkg::TGT_MMU)
	`CBAD_ASSERT_NEXT(a_drain, clk, arst_n,
		valid_s2 && m_tready && !load_s2, !valid_s2)

endmodule
